@@ design/mwr_pkg.sv @@
`timescale 1ns / 1ps
package mwr_pkg;

  localparam int TABLE_LENGTH    = 2048;
  localparam int MIP_LEVELS      = 11;
  localparam int WAVES_PER_TABLE = 8;
  localparam int NUM_TABLES      = 4;
  localparam int SAMPLE_BITS     = 16;

  // harmonic count of level 0 before the shift by level
  localparam int HARMONIC_BASE = TABLE_LENGTH / 2;

  localparam int IDX_W   = $clog2(TABLE_LENGTH);
  localparam int WAVE_W  = $clog2(WAVES_PER_TABLE);
  localparam int LEVEL_W = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
  localparam int ROWS    = NUM_TABLES * WAVES_PER_TABLE * MIP_LEVELS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = ROW_W + IDX_W;
  localparam int MEM_DEPTH = ROWS * TABLE_LENGTH;

  localparam int FRAC_W  = 16;
  localparam int POS_ONE = 65536;
  localparam int POS_W   = FRAC_W + 1;
  localparam int SCL_W   = POS_W + WAVE_W;

  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int SUM_W   = DIFF_W + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] word_t;

  typedef enum logic {
    REQ_READ = 1'b0,
    REQ_LOAD = 1'b1
  } req_e;

  // order of the four memory reads of one item
  typedef enum logic [1:0] {
    SLOT_A0,
    SLOT_A1,
    SLOT_B0,
    SLOT_B1
  } slot_e;

  typedef struct packed {
    logic              vld;
    word_t             a0;
    word_t             a1;
    word_t             b0;
    word_t             b1;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W-1:0] wfrac;
  } lerp_in_t;

  // harmonic count of a level in Q12.4
  function automatic logic [31:0] harm_thr(input int lvl);
    return 32'((HARMONIC_BASE >> lvl) * 16);
  endfunction

  function automatic word_t sat_load(input logic signed [15:0] v);
    logic signed [24:0] x;
    logic signed [24:0] hi;
    logic signed [24:0] lo;
    x  = 25'(v);
    hi = 25'((1 << (SAMPLE_BITS - 1)) - 1);
    lo = -hi - 25'sd1;
    if (x > hi) x = hi;
    else if (x < lo) x = lo;
    return x[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [15:0] sat_out(input word_t v);
    logic signed [24:0] x;
    x = 25'(v);
    if (x > 25'sd32767) x = 25'sd32767;
    else if (x < -25'sd32768) x = -25'sd32768;
    return x[15:0];
  endfunction

endpackage

@@ design/mwr_lerp.sv @@
`timescale 1ns / 1ps
module mwr_lerp
  import mwr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lerp_in_t            req_i,
  output logic                res_valid_o,
  output logic signed [15:0]  res_sample_o
);

  // stage 1: sample differences
  logic                      s1_vld_q;
  word_t                     s1_a0_q, s1_b0_q;
  logic signed [DIFF_W-1:0]  s1_da_q, s1_db_q;
  logic [FRAC_W-1:0]         s1_frac_q, s1_wfrac_q;
  logic signed [DIFF_W-1:0]  da_d, db_d;

  // stage 2: phase products
  logic                      s2_vld_q;
  word_t                     s2_a0_q, s2_b0_q;
  logic signed [PROD_W-1:0]  s2_pa_q, s2_pb_q;
  logic [FRAC_W-1:0]         s2_wfrac_q;
  logic signed [PROD_W-1:0]  pa_d, pb_d;

  // stage 3: per-wave samples and their difference
  logic                      s3_vld_q;
  word_t                     s3_sa_q;
  logic signed [DIFF_W-1:0]  s3_d_q;
  logic [FRAC_W-1:0]         s3_wfrac_q;
  logic signed [SUM_W-1:0]   sa_w, sb_w;
  word_t                     sa_d, sb_d;
  logic signed [DIFF_W-1:0]  d_d;

  // stage 4: crossfade product
  logic                      s4_vld_q;
  word_t                     s4_sa_q;
  logic signed [PROD_W-1:0]  s4_pw_q;
  logic signed [PROD_W-1:0]  pw_d;
  logic signed [SUM_W-1:0]   r_w;
  word_t                     r_c;

  assign da_d = {req_i.a1[SAMPLE_BITS-1], req_i.a1} - {req_i.a0[SAMPLE_BITS-1], req_i.a0};
  assign db_d = {req_i.b1[SAMPLE_BITS-1], req_i.b1} - {req_i.b0[SAMPLE_BITS-1], req_i.b0};

  assign pa_d = s1_da_q * $signed({1'b0, s1_frac_q});
  assign pb_d = s1_db_q * $signed({1'b0, s1_frac_q});

  // arithmetic shift of the product gives the floor
  assign sa_w = {{2{s2_a0_q[SAMPLE_BITS-1]}}, s2_a0_q} + $signed(s2_pa_q[PROD_W-1:FRAC_W]);
  assign sb_w = {{2{s2_b0_q[SAMPLE_BITS-1]}}, s2_b0_q} + $signed(s2_pb_q[PROD_W-1:FRAC_W]);
  assign sa_d = sa_w[SAMPLE_BITS-1:0];
  assign sb_d = sb_w[SAMPLE_BITS-1:0];
  assign d_d  = {sb_d[SAMPLE_BITS-1], sb_d} - {sa_d[SAMPLE_BITS-1], sa_d};

  assign pw_d = s3_d_q * $signed({1'b0, s3_wfrac_q});

  assign r_w = {{2{s4_sa_q[SAMPLE_BITS-1]}}, s4_sa_q} + $signed(s4_pw_q[PROD_W-1:FRAC_W]);
  assign r_c = r_w[SAMPLE_BITS-1:0];

  assign res_valid_o  = s4_vld_q;
  assign res_sample_o = sat_out(r_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_i.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a0_q    <= req_i.a0;
    s1_b0_q    <= req_i.b0;
    s1_da_q    <= da_d;
    s1_db_q    <= db_d;
    s1_frac_q  <= req_i.frac;
    s1_wfrac_q <= req_i.wfrac;

    s2_a0_q    <= s1_a0_q;
    s2_b0_q    <= s1_b0_q;
    s2_pa_q    <= pa_d;
    s2_pb_q    <= pb_d;
    s2_wfrac_q <= s1_wfrac_q;

    s3_sa_q    <= sa_d;
    s3_d_q     <= d_d;
    s3_wfrac_q <= s2_wfrac_q;

    s4_sa_q    <= s3_sa_q;
    s4_pw_q    <= pw_d;
  end

endmodule

@@ design/mipmapped_wavetable_reader.sv @@
`timescale 1ns / 1ps
// channel   signals                                   direction
// -------   ---------------------------------------   ---------
// request   in_valid_i / in_ready_o, req_type_i ...   in
// result    out_valid_o / out_ready_i, sample_o       out
//
// a read makes four reads of the single memory read port, and the next read can enter
// during the last of them; loads enter one per cycle when at most that last read is left to issue
// a read result passes through the interpolator pipeline and a 4-entry output queue
// request ready drops while 4 results are outstanding (in flight or queued)
// reset clears control only; the sample memory holds garbage until loaded
module mipmapped_wavetable_reader
  import mwr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [3:0]          table_select_i,
  input  logic signed [17:0]  wave_position_i,
  input  logic [31:0]         phase_i,
  input  logic [15:0]         harmonic_limit_i,
  input  logic [2:0]          load_wave_i,
  input  logic [3:0]          load_level_i,
  input  logic [10:0]         load_index_i,
  input  logic signed [15:0]  load_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  sample_o
);

  logic                in_fire, rd_fire, ld_fire, pop;
  logic [3:0]          tbl_c;
  logic [LEVEL_W-1:0]  lvl_c;
  logic [POS_W-1:0]    pos_c;
  logic [SCL_W-1:0]    scaled_c;
  logic [WAVE_W-1:0]   wa_c, wb_c;
  logic [FRAC_W-1:0]   wf_c, f_c;
  logic [IDX_W-1:0]    i0_c;
  logic [ROW_W-1:0]    row_a_c, row_b_c, ld_row_c;
  logic                ld_ok_c;

  // request registers of the item being issued
  logic [ROW_W-1:0]    row_a_q, row_b_q;
  logic [IDX_W-1:0]    i0_q, i1_q;
  logic [FRAC_W-1:0]   f_q, wf_q;

  logic                busy_q, busy_d;
  slot_e               slot_q, slot_d;
  logic                issue_last;

  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic                wr_en;
  word_t               wr_data;
  word_t               mem [MEM_DEPTH];
  word_t               mem_q;

  logic                rd_vld_q;
  slot_e               rd_slot_q;
  logic [FRAC_W-1:0]   rd_f_q, rd_wf_q;
  word_t               s_a0_q, s_a1_q, s_b0_q;

  lerp_in_t            lerp_in;
  logic                res_vld;
  logic signed [15:0]  res_sample;

  logic signed [15:0]  fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    fifo_cnt_q, fifo_cnt_d;
  logic [CNT_W-1:0]    used_q, used_d;

  assign issue_last = busy_q && (slot_q == SLOT_B1);
  assign in_ready_o = (!busy_q || issue_last) && (used_q < CNT_W'(FIFO_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_fire    = in_fire && (req_e'(req_type_i) == REQ_READ);
  assign ld_fire    = in_fire && (req_e'(req_type_i) == REQ_LOAD);
  assign pop        = out_valid_o && out_ready_i;

  // request decode
  always_comb begin
    tbl_c = (32'(table_select_i) > NUM_TABLES - 1) ? 4'(NUM_TABLES - 1) : table_select_i;

    // first level whose harmonic count fits under the limit
    lvl_c = LEVEL_W'(MIP_LEVELS - 1);
    for (int l = MIP_LEVELS - 2; l >= 0; l--) begin
      if (harm_thr(l) <= {16'd0, harmonic_limit_i}) lvl_c = LEVEL_W'(l);
    end

    if (wave_position_i[17]) pos_c = '0;
    else if (wave_position_i > 18'sd65536) pos_c = POS_W'(POS_ONE);
    else pos_c = wave_position_i[POS_W-1:0];
    scaled_c = SCL_W'(pos_c) * SCL_W'(WAVES_PER_TABLE - 1);
    wa_c     = scaled_c[FRAC_W +: WAVE_W];
    wf_c     = scaled_c[FRAC_W-1:0];
    wb_c     = (32'(wa_c) == WAVES_PER_TABLE - 1) ? wa_c : wa_c + WAVE_W'(1);

    row_a_c = (ROW_W'(tbl_c) * ROW_W'(WAVES_PER_TABLE) + ROW_W'(wa_c))
              * ROW_W'(MIP_LEVELS) + ROW_W'(lvl_c);
    row_b_c = (ROW_W'(tbl_c) * ROW_W'(WAVES_PER_TABLE) + ROW_W'(wb_c))
              * ROW_W'(MIP_LEVELS) + ROW_W'(lvl_c);

    i0_c = phase_i[31 -: IDX_W];
    f_c  = phase_i[31-IDX_W -: FRAC_W];

    ld_ok_c  = (32'(table_select_i) < NUM_TABLES) && (32'(load_wave_i) < WAVES_PER_TABLE)
               && (32'(load_level_i) < MIP_LEVELS) && (32'(load_index_i) < TABLE_LENGTH);
    ld_row_c = (ROW_W'(table_select_i) * ROW_W'(WAVES_PER_TABLE) + ROW_W'(load_wave_i))
               * ROW_W'(MIP_LEVELS) + ROW_W'(load_level_i);
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      row_a_q <= row_a_c;
      row_b_q <= row_b_c;
      i0_q    <= i0_c;
      i1_q    <= i0_c + IDX_W'(1);
      f_q     <= f_c;
      wf_q    <= wf_c;
    end
  end

  // read issue sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= SLOT_A0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (busy_q) begin
      case (slot_q)
        SLOT_A0: slot_d = SLOT_A1;
        SLOT_A1: slot_d = SLOT_B0;
        SLOT_B0: slot_d = SLOT_B1;
        SLOT_B1: begin
          slot_d = SLOT_A0;
          busy_d = 1'b0;
        end
        default: slot_d = SLOT_A0;
      endcase
    end
    if (rd_fire) begin
      busy_d = 1'b1;
      slot_d = SLOT_A0;
    end
  end

  // sample memory; a load never overlaps pending reads, and a load in the cycle of
  // the last read sees that read take the old word
  always_comb begin
    rd_addr = {((slot_q == SLOT_A0) || (slot_q == SLOT_A1)) ? row_a_q : row_b_q,
               ((slot_q == SLOT_A0) || (slot_q == SLOT_B0)) ? i0_q : i1_q};
    wr_addr = {ld_row_c, load_index_i[IDX_W-1:0]};
    wr_en   = ld_fire && ld_ok_c;
    wr_data = sat_load(load_value_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (busy_q) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= slot_q;
    rd_f_q    <= f_q;
    rd_wf_q   <= wf_q;
    if (rd_vld_q) begin
      case (rd_slot_q)
        SLOT_A0: s_a0_q <= mem_q;
        SLOT_A1: s_a1_q <= mem_q;
        SLOT_B0: s_b0_q <= mem_q;
        default: ;
      endcase
    end
  end

  always_comb begin
    lerp_in.vld   = rd_vld_q && (rd_slot_q == SLOT_B1);
    lerp_in.a0    = s_a0_q;
    lerp_in.a1    = s_a1_q;
    lerp_in.b0    = s_b0_q;
    lerp_in.b1    = mem_q;
    lerp_in.frac  = rd_f_q;
    lerp_in.wfrac = rd_wf_q;
  end

  mwr_lerp u_lerp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (lerp_in),
    .res_valid_o  (res_vld),
    .res_sample_o (res_sample)
  );

  // output queue and outstanding-result count
  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (res_vld && !pop) fifo_cnt_d = fifo_cnt_q + CNT_W'(1);
    else if (!res_vld && pop) fifo_cnt_d = fifo_cnt_q - CNT_W'(1);

    used_d = used_q;
    if (rd_fire && !pop) used_d = used_q + CNT_W'(1);
    else if (!rd_fire && pop) used_d = used_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      used_q     <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      used_q     <= used_d;
      if (res_vld) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) fifo_q[wr_ptr_q] <= res_sample;
  end

  assign out_valid_o = (fifo_cnt_q != '0);
  assign sample_o    = fifo_q[rd_ptr_q];

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> (fifo_cnt_q < CNT_W'(FIFO_DEPTH)))
    else $error("result pushed into full output queue");

  a_credit_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q <= used_q) && (used_q <= CNT_W'(FIFO_DEPTH)))
    else $error("outstanding count out of step with output queue");

  a_issue_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (slot_q != SLOT_B1)) |=> busy_q)
    else $error("read issue broke off before the fourth read");

  a_load_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!busy_q || (slot_q == SLOT_B1)))
    else $error("load written while reads of an earlier item are pending");
`endif

endmodule
